// ===== sv/sle_pkg.sv =====
`default_nettype none

package sle_pkg;

    localparam int DEF_DEPTH = 16;
    localparam int CNT_W     = 5;
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int TDATA_W   = 40;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_DEL_VAL = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== sv/sle_store.sv =====
`default_nettype none

module sle_store #(
    parameter int DEPTH = sle_pkg::DEF_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [AW-1:0]             i_wr_addr,
    input  wire logic [sle_pkg::DATA_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]             i_rd_addr,
    output logic      [sle_pkg::DATA_W-1:0] o_rd_data
);
    import sle_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/sle_ctrl.sv =====
`default_nettype none

module sle_ctrl #(
    parameter int DEPTH = sle_pkg::DEF_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [sle_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire sle_pkg::t_cmd              i_cmd,
    input  wire logic [sle_pkg::POS_W-1:0]  i_pos,
    input  wire logic [sle_pkg::DATA_W-1:0] i_val,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output sle_pkg::t_status                o_status,
    output logic      [sle_pkg::DATA_W-1:0] o_data,
    output logic      [sle_pkg::CNT_W-1:0]  o_count,
    output logic                            o_wr_en,
    output logic      [AW-1:0]              o_wr_addr,
    output logic      [sle_pkg::DATA_W-1:0] o_wr_data,
    output logic      [AW-1:0]              o_rd_addr,
    input  wire logic [sle_pkg::DATA_W-1:0] i_rd_data
);
    import sle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cap, n_cap;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    t_cmd                r_cmd, n_cmd;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [DATA_W-1:0]   r_val, n_val;
    logic [CNT_W-1:0]    r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]    r_stop, n_stop;
    logic                r_reading, n_reading;
    logic                r_pend, n_pend;
    logic [CNT_W-1:0]    r_pend_idx, n_pend_idx;
    logic [CNT_W-1:0]    r_kept, n_kept;
    t_status             r_status, n_status;
    logic [DATA_W-1:0]   r_data, n_data;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic [CNT_W-1:0]    r_out_count, n_out_count;

    logic [CNT_W-1:0]    w_cap_lim;
    logic                w_accept;
    logic                w_keep;
    logic                w_done;
    logic                w_out_free;
    logic [CNT_W-1:0]    w_wr_idx;
    logic [CNT_W-1:0]    w_pos_m1;
    logic [CNT_W-1:0]    w_cnt_m1;

    // usable capacity never exceeds the store
    assign w_cap_lim  = (32'(r_cap) > 32'(DEPTH)) ? CNT_W'(DEPTH) : r_cap;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_keep     = r_pend && (r_cmd == CMD_DEL_VAL) && (i_rd_data != r_val);
    assign w_done     = !r_reading && (!r_pend || (r_cmd != CMD_INSERT));
    assign w_pos_m1   = i_pos - 1'b1;
    assign w_cnt_m1   = r_cnt - 1'b1;

    always_comb begin
        n_state      = r_state;
        n_cap        = i_cfg_we ? i_cfg_wdata : r_cap;
        n_cnt        = r_cnt;
        n_cmd        = r_cmd;
        n_pos        = r_pos;
        n_val        = r_val;
        n_rd_idx     = r_rd_idx;
        n_stop       = r_stop;
        n_reading    = r_reading;
        n_pend       = 1'b0;
        n_pend_idx   = r_rd_idx;
        n_kept       = r_kept;
        n_status     = r_status;
        n_data       = r_data;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_count  = r_out_count;
        o_wr_en      = 1'b0;
        w_wr_idx     = '0;
        o_wr_data    = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd     = i_cmd;
                    n_pos     = i_pos;
                    n_val     = i_val;
                    n_kept    = '0;
                    n_data    = '0;
                    n_status  = ST_OK;
                    n_reading = 1'b1;
                    n_state   = S_RUN;
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            n_rd_idx  = w_cnt_m1;
                            n_stop    = w_pos_m1;
                            n_reading = (i_pos <= r_cnt);
                            if (r_cnt >= w_cap_lim) begin
                                n_status = ST_FULL;
                            end else if ((i_pos == '0) ||
                                         ({1'b0, i_pos} > ({1'b0, r_cnt} + 1'b1))) begin
                                n_status = ST_RANGE;
                            end
                        end
                        CMD_DELETE, CMD_READ: begin
                            n_rd_idx = w_pos_m1;
                            n_stop   = (i_cmd == CMD_READ) ? w_pos_m1 : w_cnt_m1;
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else if ((i_pos == '0) || (i_pos > r_cnt)) begin
                                n_status = ST_RANGE;
                            end
                        end
                        CMD_DEL_VAL: begin
                            n_rd_idx = '0;
                            n_stop   = w_cnt_m1;
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                    if (n_status != ST_OK) begin
                        n_reading = 1'b0;
                        n_state   = S_FIN;
                    end
                end
            end
            S_RUN: begin
                // issue one read per cycle, walking toward the stop index
                if (r_reading) begin
                    n_pend = 1'b1;
                    if (r_rd_idx == r_stop) begin
                        n_reading = 1'b0;
                    end else if (r_cmd == CMD_INSERT) begin
                        n_rd_idx = r_rd_idx - 1'b1;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
                // write back, or capture as the result, the word that arrives from the read issued last cycle
                if (r_pend) begin
                    case (r_cmd)
                        CMD_INSERT: begin
                            o_wr_en  = 1'b1;
                            w_wr_idx = r_pend_idx + 1'b1;
                        end
                        CMD_DELETE: begin
                            if (r_pend_idx == (r_pos - 1'b1)) begin
                                n_data = i_rd_data;
                            end else begin
                                o_wr_en  = 1'b1;
                                w_wr_idx = r_pend_idx - 1'b1;
                            end
                        end
                        CMD_DEL_VAL: begin
                            o_wr_en  = w_keep;
                            w_wr_idx = r_kept;
                            if (w_keep) begin
                                n_kept = r_kept + 1'b1;
                            end
                        end
                        default: begin
                            n_data = i_rd_data;
                        end
                    endcase
                end else if (w_done && (r_cmd == CMD_INSERT)) begin
                    o_wr_en   = 1'b1;
                    w_wr_idx  = r_pos - 1'b1;
                    o_wr_data = r_val;
                end
                if (w_done) begin
                    n_state = S_FIN;
                    case (r_cmd)
                        CMD_INSERT:  n_cnt = r_cnt + 1'b1;
                        CMD_DELETE:  n_cnt = w_cnt_m1;
                        CMD_DEL_VAL: n_cnt = r_kept + CNT_W'(w_keep);
                        default:     n_cnt = r_cnt;
                    endcase
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_data   = r_data;
                    n_out_count  = r_cnt;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_wr_addr = AW'(w_wr_idx);
    assign o_rd_addr = AW'(r_rd_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_cnt       <= '0;
            r_reading   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_cnt       <= n_cnt;
            r_reading   <= n_reading;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_rd_idx     <= n_rd_idx;
        r_stop       <= n_stop;
        r_pend_idx   <= n_pend_idx;
        r_kept       <= n_kept;
        r_status     <= n_status;
        r_data       <= n_data;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_count  <= n_out_count;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_out_status;
    assign o_data     = r_out_data;
    assign o_count    = r_out_count;

endmodule

`default_nettype wire

// ===== sv/sequential_list_engine.sv =====
// Channel   Dir  Handshake          Payload
// cfg       in   i_cfg_we           i_cfg_wdata = capacity
// s (cmd)   in   i_s_tvalid/tready  tuser = command; tdata = position, value
// m (res)   out  o_m_tvalid/tready  tuser = status;  tdata = data_out, count
//
// A good command walks its entries in S_RUN and then passes S_FIN; an insert that moves entries
// writes the new value after the last move. Failed commands skip S_RUN. One read and one write
// port, one entry per cycle (insert and delete: the tail from the position,
// delete-by-value: the whole list, read: one entry).
// A result waiting in the output register stalls only the next command's S_FIN state.
// Reset is synchronous; entries are not cleared, only the count and the capacity.
`default_nettype none

module sequential_list_engine #(
    parameter int DEPTH = sle_pkg::DEF_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [sle_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [1:0]                  i_s_tuser,  // command
    input  wire logic [sle_pkg::TDATA_W-1:0] i_s_tdata,  // position[4:0], value[36:5]
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic      [1:0]                  o_m_tuser,  // status
    output logic      [sle_pkg::TDATA_W-1:0] o_m_tdata   // data_out[31:0], count[36:32]
);
    import sle_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [AW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;
    t_status           w_status;
    logic [DATA_W-1:0] w_data;
    logic [CNT_W-1:0]  w_count;

    sle_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_cmd       (t_cmd'(i_s_tuser)),
        .i_pos       (i_s_tdata[POS_W-1:0]),
        .i_val       (i_s_tdata[POS_W+DATA_W-1:POS_W]),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_status    (w_status),
        .o_data      (w_data),
        .o_count     (w_count),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    sle_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_m_tuser = w_status;
    assign o_m_tdata = {(TDATA_W - DATA_W - CNT_W)'(0), w_count, w_data};

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_wr_en)
        else $error("entry memory written while engine idle");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (32'(w_wr_addr) < 32'(DEPTH)))
        else $error("entry write beyond store");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(w_count) <= 32'(DEPTH)))
        else $error("count exceeds store depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_status == ST_EMPTY)) |-> (w_count == '0))
        else $error("empty status with nonzero count");

    a_full_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_status != ST_OK)) |-> (w_data == '0))
        else $error("failed command returned data");
`endif

endmodule

`default_nettype wire

// ===== dv/sequential_list_engine_tb.sv =====
`default_nettype none

module sequential_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    typedef struct {
        t_status     status;
        logic [31:0] data;
        logic [4:0]  count;
    } t_list_result;

    class t_list_scoreboard;
        logic [31:0]  store [DEF_DEPTH];
        int           count;
        int           capacity;
        int           errors;
        t_list_result pending [$];

        function new();
            count    = 0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        // update the list image for one accepted command and queue its result
        function void note_command(t_cmd cmd, logic [4:0] pos, logic [31:0] val);
            t_list_result res;
            int           usable;
            int           p;
            int           kept;
            usable     = (capacity > DEF_DEPTH) ? DEF_DEPTH : capacity;
            p          = pos;
            res.status = ST_OK;
            res.data   = '0;
            case (cmd) inside
                CMD_INSERT: begin
                    if (count >= usable) begin
                        res.status = ST_FULL;
                    end else if (p < 1 || p > count + 1) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (int j = count; j >= p; j--) store[j] = store[j-1];
                        store[p-1] = val;
                        count++;
                    end
                end
                CMD_DELETE, CMD_READ: begin
                    if (count == 0) begin
                        res.status = ST_EMPTY;
                    end else if (p < 1 || p > count) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.data = store[p-1];
                        if (cmd == CMD_DELETE) begin
                            for (int j = p - 1; j + 1 < count; j++) store[j] = store[j+1];
                            count--;
                        end
                    end
                end
                CMD_DEL_VAL: begin
                    if (count == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        kept = 0;
                        for (int j = 0; j < count; j++) begin
                            if (store[j] != val) begin
                                store[kept] = store[j];
                                kept++;
                            end
                        end
                        count = kept;
                    end
                end
            endcase
            res.count = 5'(count);
            pending.push_back(res);
        endfunction

        function void check_result(logic [1:0] st, logic [TDATA_W-1:0] td);
            t_list_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d data %h count %0d",
                             st, td[31:0], td[36:32]);
                return;
            end
            want = pending.pop_front();
            if (st !== want.status || td[31:0] !== want.data || td[36:32] !== want.count) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st %0d data %h cnt %0d, got st %0d data %h cnt %0d",
                             want.status, want.data, want.count, st, td[31:0], td[36:32]);
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CNT_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [1:0]           s_tuser   = '0;  // command
    logic [TDATA_W-1:0]   s_tdata   = '0;  // position[4:0], value[36:5]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [1:0]           m_tuser;         // status
    logic [TDATA_W-1:0]   m_tdata;         // data_out[31:0], count[36:32]
    bit                   steady    = 1'b0;

    t_list_scoreboard sb = new();

    sequential_list_engine u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tuser   (s_tuser),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tuser   (m_tuser),
        .o_m_tdata   (m_tdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_command(t_cmd cmd, logic [4:0] pos, logic [31:0] val);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, val, pos};
        do @(posedge clk); while (!s_tready);
        sb.note_command(cmd, pos, val);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CNT_W-1:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.capacity = cap;
    endtask

    // mostly legal positions; values often from a small pool or the list so deletes by value hit
    task automatic pick_command(output t_cmd cmd, output logic [4:0] pos,
                                output logic [31:0] val);
        int r;
        int cnt;
        int lim;
        cnt = sb.count;
        r   = $urandom_range(0, 99);
        if (r < 40)      cmd = CMD_INSERT;
        else if (r < 60) cmd = CMD_DELETE;
        else if (r < 70) cmd = CMD_DEL_VAL;
        else             cmd = CMD_READ;
        lim = (cmd == CMD_INSERT) ? cnt + 1 : ((cnt == 0) ? 1 : cnt);
        if ($urandom_range(0, 9) < 8) pos = 5'($urandom_range(1, lim));
        else                          pos = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 9)) inside
            0:       val = 32'h0000_0000;
            1:       val = 32'h8000_0000;
            2:       val = 32'h7fff_ffff;
            3:       val = 32'hffff_ffff;
            4, 5:    val = $urandom_range(0, 3);
            default: val = $urandom;
        endcase
        if (cmd == CMD_DEL_VAL && cnt > 0 && $urandom_range(0, 9) < 6)
            val = sb.store[$urandom_range(0, cnt - 1)];
    endtask

    // result side; one long hold-off lets the engine back up into its input
    initial begin
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        forever begin
            @(posedge clk);
            if (m_tready && m_tvalid) begin
                sb.check_result(m_tuser, m_tdata);
                taken++;
            end
            if (taken == 400 && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 20);
        end
    end

    initial begin
        int       caps [11];
        t_cmd     cmd;
        logic [4:0]  pos;
        logic [31:0] val;
        caps = '{31, 16, 1, 0, 2, 17, 8, 16, 24, 3, 5};
        caps[10] = $urandom_range(0, 31);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, position bounds, head / middle / tail, duplicate removal
        send_command(CMD_READ,    5'd1,  32'd0);
        send_command(CMD_DELETE,  5'd1,  32'd0);
        send_command(CMD_DEL_VAL, 5'd0,  32'd0);
        send_command(CMD_INSERT,  5'd0,  32'd1);
        send_command(CMD_INSERT,  5'd2,  32'd1);
        send_command(CMD_INSERT,  5'd1,  32'h7fff_ffff);
        send_command(CMD_INSERT,  5'd1,  32'h8000_0000);
        send_command(CMD_INSERT,  5'd3,  32'hffff_ffff);
        send_command(CMD_INSERT,  5'd31, 32'd0);
        send_command(CMD_INSERT,  5'd5,  32'd0);
        send_command(CMD_READ,    5'd0,  32'd0);
        send_command(CMD_READ,    5'd4,  32'd0);
        send_command(CMD_READ,    5'd3,  32'd0);
        send_command(CMD_DELETE,  5'd2,  32'd0);
        send_command(CMD_INSERT,  5'd2,  32'd5);
        send_command(CMD_INSERT,  5'd2,  32'd5);
        send_command(CMD_INSERT,  5'd4,  32'd0);
        send_command(CMD_DEL_VAL, 5'd0,  32'd5);
        send_command(CMD_DEL_VAL, 5'd31, 32'd12345);
        send_command(CMD_DELETE,  5'd31, 32'd0);
        send_command(CMD_DELETE,  5'd4,  32'd0);
        // capacity dropped below the current count
        drain_results();
        set_capacity(5'd1);
        send_command(CMD_INSERT,  5'd1,  32'd9);
        send_command(CMD_READ,    5'd1,  32'd0);
        send_command(CMD_DELETE,  5'd3,  32'd0);
        send_command(CMD_DELETE,  5'd1,  32'd0);
        drain_results();
        set_capacity(5'd0);
        send_command(CMD_INSERT,  5'd1,  32'd9);

        for (int ph = 0; ph < 11; ph++) begin
            drain_results();
            set_capacity(5'(caps[ph]));
            steady = (ph == 5 || ph == 6);
            for (int n = 0; n < 150; n++) begin
                pick_command(cmd, pos, val);
                send_command(cmd, pos, val);
            end
        end
        drain_results();
        steady = 1'b0;
        repeat (40) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/sle_pkg.sv
sv/sle_store.sv
sv/sle_ctrl.sv
sv/sequential_list_engine.sv
dv/sequential_list_engine_tb.sv
